/* rtl/core/cwm_pkg.sv */
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types and constants of the co-association weight matrix block:
// command codes, configuration register indexes and the item layouts.
// ----------------------------------------------------------------------------
package cwm_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ROW   = 2'd1,
        CMD_EDGES = 2'd2
    } cwm_cmd_t;

    localparam int unsigned CFG_INDEX_BITS        = 1;
    localparam int unsigned CFG_DATA_BITS         = 7;
    localparam int unsigned ELEMENT_COUNT_BITS    = 7;
    localparam int unsigned CLUSTERING_COUNT_BITS = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLUSTERING_COUNT = 1'b1;

    localparam logic [ELEMENT_COUNT_BITS-1:0]    ELEMENT_COUNT_RESET    = 7'd64;
    localparam logic [CLUSTERING_COUNT_BITS-1:0] CLUSTERING_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] clustering_index;
        logic [5:0] element_index;
        logic [7:0] label_value;
    } cwm_item_t;

    typedef struct packed {
        logic        has_entry;
        logic [5:0]  neighbor_index;
        logic [4:0]  weight;
        logic [10:0] edge_count;
        logic        last;
    } cwm_result_t;

endpackage

/* rtl/core/cwm_channels.sv */
// ----------------------------------------------------------------------------
// cwm channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cwm_item_if;
    import cwm_pkg::*;

    logic      valid;
    logic      ready;
    cwm_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cwm_result_if;
    import cwm_pkg::*;

    logic        valid;
    logic        ready;
    cwm_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/coassociation_weight_matrix.sv */
// ----------------------------------------------------------------------------
// coassociation_weight_matrix
// A load reads the stored label vector and writes it back with one lane
// replaced. A row query reads one stored element per cycle through the single
// read port of the label memory, except while the result side stalls. An
// edge-count query scans every pair of elements in use.
// Reset sets element_count to 64 and clustering_count to 16; the label
// memory is not cleared and holds no value until written.
// ----------------------------------------------------------------------------
module coassociation_weight_matrix #(
    parameter int unsigned MAX_ELEMENTS    = 64,
    parameter int unsigned MAX_CLUSTERINGS = 16,
    parameter int unsigned LABEL_BITS      = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cwm_pkg::CFG_INDEX_BITS-1:0]  cfg_addr,
    input  logic [cwm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    cwm_item_if.sink                            items,
    cwm_result_if.source                        results
);

    import cwm_pkg::*;

    localparam int unsigned EW     = $clog2(MAX_ELEMENTS);
    localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned NCW    = $clog2(MAX_CLUSTERINGS + 1);
    localparam int unsigned CW     = (MAX_CLUSTERINGS > 1) ? $clog2(MAX_CLUSTERINGS) : 1;
    localparam int unsigned W      = MAX_CLUSTERINGS * LABEL_BITS;
    localparam int unsigned PAIRS  = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
    localparam int unsigned EC_W   = $clog2(PAIRS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROWVEC,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t                            state_reg, state_next;
    logic [ELEMENT_COUNT_BITS-1:0]     element_count_reg;
    logic [CLUSTERING_COUNT_BITS-1:0]  clustering_count_reg;
    logic                              edge_mode_reg, edge_mode_next;
    logic [EW-1:0]                     row_reg, row_next;
    logic [CNT_W-1:0]                  j_reg, j_next;
    logic                              d_vld_reg, d_vld_next;
    logic [EW-1:0]                     d_idx_reg, d_idx_next;
    logic [W-1:0]                      rowvec_reg, rowvec_next;
    logic                              pend_vld_reg, pend_vld_next;
    logic [EW-1:0]                     pend_idx_reg, pend_idx_next;
    logic [NCW-1:0]                    pend_w_reg, pend_w_next;
    logic [EC_W-1:0]                   ecount_reg, ecount_next;
    logic [CW-1:0]                     load_lane_reg, load_lane_next;
    logic [LABEL_BITS-1:0]             load_label_reg, load_label_next;
    logic                              out_vld_reg, out_vld_next;
    cwm_result_t                       out_data_reg, out_data_next;

    logic [CNT_W-1:0]  ne;
    logic [NCW-1:0]    nc;
    logic [CNT_W-1:0]  next_row;
    logic              ram_we;
    logic              ram_re;
    logic [EW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_raddr;
    logic [W-1:0]      ram_wdata;
    logic [W-1:0]      ram_rdata;
    logic [NCW-1:0]    weight;
    logic              agree;
    logic              cand;
    logic              issue;
    logic              out_full;
    logic              stall;

    always_comb
    begin
        if (element_count_reg == '0)
        begin
            ne = CNT_W'(1);
        end
        else if (int'(element_count_reg) > MAX_ELEMENTS)
        begin
            ne = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            ne = CNT_W'(element_count_reg);
        end

        if (clustering_count_reg == '0)
        begin
            nc = NCW'(1);
        end
        else if (int'(clustering_count_reg) > MAX_CLUSTERINGS)
        begin
            nc = NCW'(MAX_CLUSTERINGS);
        end
        else
        begin
            nc = NCW'(clustering_count_reg);
        end
    end

    cwm_ram #(
        .WIDTH (W),
        .DEPTH (MAX_ELEMENTS)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cwm_match #(
        .MAX_CLUSTERINGS (MAX_CLUSTERINGS),
        .LABEL_BITS      (LABEL_BITS)
    ) u_match (
        .row_word   (rowvec_reg),
        .cand_word  (ram_rdata),
        .lanes_used (nc),
        .weight     (weight),
        .agree      (agree)
    );

    assign next_row = CNT_W'(row_reg) + CNT_W'(1);
    assign issue    = j_reg < ne;
    assign cand     = d_vld_reg && (d_idx_reg != row_reg) && agree;
    assign out_full = out_vld_reg && !results.ready;
    assign stall    = cand && pend_vld_reg && out_full;

    always_comb
    begin
        ram_wdata = ram_rdata;
        ram_wdata[load_lane_reg*LABEL_BITS +: LABEL_BITS] = load_label_reg;
    end

    assign ram_waddr = row_reg;

    always_comb
    begin
        state_next      = state_reg;
        edge_mode_next  = edge_mode_reg;
        row_next        = row_reg;
        j_next          = j_reg;
        d_vld_next      = d_vld_reg;
        d_idx_next      = d_idx_reg;
        rowvec_next     = rowvec_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        pend_w_next     = pend_w_reg;
        ecount_next     = ecount_reg;
        load_lane_next  = load_lane_reg;
        load_label_next = load_label_reg;
        out_vld_next    = out_full;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = j_reg[EW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    unique case (items.data.command)
                        CMD_LOAD:
                        begin
                            if ((int'(items.data.clustering_index) < MAX_CLUSTERINGS) &&
                                (int'(items.data.element_index) < MAX_ELEMENTS))
                            begin
                                ram_re          = 1'b1;
                                ram_raddr       = EW'(items.data.element_index);
                                row_next        = EW'(items.data.element_index);
                                load_lane_next  = CW'(items.data.clustering_index);
                                load_label_next = LABEL_BITS'(items.data.label_value);
                                state_next      = S_LOAD;
                            end
                        end
                        CMD_ROW:
                        begin
                            edge_mode_next = 1'b0;
                            pend_vld_next  = 1'b0;
                            if (int'(items.data.element_index) < int'(ne))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = EW'(items.data.element_index);
                                row_next   = EW'(items.data.element_index);
                                state_next = S_ROWVEC;
                            end
                            else
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                        CMD_EDGES:
                        begin
                            edge_mode_next = 1'b1;
                            pend_vld_next  = 1'b0;
                            ecount_next    = '0;
                            ram_re         = 1'b1;
                            ram_raddr      = '0;
                            row_next       = '0;
                            state_next     = S_ROWVEC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end

            S_ROWVEC:
            begin
                rowvec_next = ram_rdata;
                j_next      = edge_mode_reg ? next_row : '0;
                d_vld_next  = 1'b0;
                state_next  = S_SCAN;
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (issue)
                    begin
                        ram_re = 1'b1;
                        j_next = j_reg + CNT_W'(1);
                    end
                    d_vld_next = issue;
                    d_idx_next = j_reg[EW-1:0];

                    if (cand)
                    begin
                        if (edge_mode_reg)
                        begin
                            ecount_next = ecount_reg + EC_W'(1);
                        end
                        else
                        begin
                            if (pend_vld_reg)
                            begin
                                out_vld_next                 = 1'b1;
                                out_data_next.has_entry      = 1'b1;
                                out_data_next.neighbor_index = 6'(pend_idx_reg);
                                out_data_next.weight         = 5'(pend_w_reg);
                                out_data_next.edge_count     = '0;
                                out_data_next.last           = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_idx_next = d_idx_reg;
                            pend_w_next   = weight;
                        end
                    end

                    if (!issue && !d_vld_reg)
                    begin
                        if (edge_mode_reg && (next_row < ne - CNT_W'(1)))
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = next_row[EW-1:0];
                            row_next   = next_row[EW-1:0];
                            state_next = S_ROWVEC;
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end

            S_DRAIN:
            begin
                if (!out_full)
                begin
                    out_vld_next = 1'b1;
                    out_data_next.last = 1'b1;
                    if (edge_mode_reg)
                    begin
                        out_data_next.has_entry      = 1'b0;
                        out_data_next.neighbor_index = '0;
                        out_data_next.weight         = '0;
                        out_data_next.edge_count     = 11'(ecount_reg);
                    end
                    else if (pend_vld_reg)
                    begin
                        out_data_next.has_entry      = 1'b1;
                        out_data_next.neighbor_index = 6'(pend_idx_reg);
                        out_data_next.weight         = 5'(pend_w_reg);
                        out_data_next.edge_count     = '0;
                    end
                    else
                    begin
                        out_data_next.has_entry      = 1'b0;
                        out_data_next.neighbor_index = '0;
                        out_data_next.weight         = '0;
                        out_data_next.edge_count     = '0;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            element_count_reg    <= ELEMENT_COUNT_RESET;
            clustering_count_reg <= CLUSTERING_COUNT_RESET;
            edge_mode_reg        <= 1'b0;
            row_reg              <= '0;
            j_reg                <= '0;
            d_vld_reg            <= 1'b0;
            d_idx_reg            <= '0;
            rowvec_reg           <= '0;
            pend_vld_reg         <= 1'b0;
            pend_idx_reg         <= '0;
            pend_w_reg           <= '0;
            ecount_reg           <= '0;
            load_lane_reg        <= '0;
            load_label_reg       <= '0;
            out_vld_reg          <= 1'b0;
            out_data_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ELEMENT_COUNT:
                    begin
                        element_count_reg <= cfg_data[ELEMENT_COUNT_BITS-1:0];
                    end
                    REG_CLUSTERING_COUNT:
                    begin
                        clustering_count_reg <= cfg_data[CLUSTERING_COUNT_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            state_reg      <= state_next;
            edge_mode_reg  <= edge_mode_next;
            row_reg        <= row_next;
            j_reg          <= j_next;
            d_vld_reg      <= d_vld_next;
            d_idx_reg      <= d_idx_next;
            rowvec_reg     <= rowvec_next;
            pend_vld_reg   <= pend_vld_next;
            pend_idx_reg   <= pend_idx_next;
            pend_w_reg     <= pend_w_next;
            ecount_reg     <= ecount_next;
            load_lane_reg  <= load_lane_next;
            load_label_reg <= load_label_next;
            out_vld_reg    <= out_vld_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign items.ready   = (state_reg == S_IDLE);
    assign results.valid = out_vld_reg;
    assign results.data  = out_data_reg;

    a_read_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> (state_reg == S_SCAN))
        else $error("Read pipeline holds an element outside the scan.");

    a_pending_row_only: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> !edge_mode_reg)
        else $error("A pending neighbor exists during an edge count.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg <= ne))
        else $error("Scan address ran past the elements in use.");

    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!ram_re && $past(ram_re)))
        else $error("Label write-back without its preceding read.");

endmodule

/* rtl/core/cwm_ram.sv */
// ----------------------------------------------------------------------------
// cwm_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module cwm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/cwm_match.sv */
// ----------------------------------------------------------------------------
// cwm_match
// Compares two label vectors lane by lane over the clusterings in use and
// counts the agreeing lanes.
// ----------------------------------------------------------------------------
module cwm_match #(
    parameter int unsigned MAX_CLUSTERINGS = 16,
    parameter int unsigned LABEL_BITS      = 8,
    parameter int unsigned NCW             = $clog2(MAX_CLUSTERINGS + 1)
) (
    input  logic [MAX_CLUSTERINGS*LABEL_BITS-1:0] row_word,
    input  logic [MAX_CLUSTERINGS*LABEL_BITS-1:0] cand_word,
    input  logic [NCW-1:0]                        lanes_used,
    output logic [NCW-1:0]                        weight,
    output logic                                  agree
);

    logic [MAX_CLUSTERINGS-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < MAX_CLUSTERINGS; k++)
        begin
            hit[k] = (k < int'(lanes_used)) &&
                     (row_word[k*LABEL_BITS +: LABEL_BITS] ==
                      cand_word[k*LABEL_BITS +: LABEL_BITS]);
        end
    end

    assign weight = NCW'($countones(hit));
    assign agree  = |hit;

endmodule
